// ----- rtl/qs3_pkg.sv -----
package qs3_pkg;

  // normalized magnitude width, top bit of the largest component sits at bit 29
  localparam int MAG_W  = 30;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 62;
  localparam int ROOT_W = 31;
  localparam int TRY_W  = SUM_W + 2;

  // scaled component in Q0.24 and the byte mapping
  localparam int A_W    = 25;
  localparam int COEF_W = 24;
  localparam int T_W    = A_W + COEF_W;
  localparam int W_W    = T_W + 1;
  localparam int BYTE_W = 8;
  localparam int FRAC_W = 48;
  localparam int SCL_W  = W_W + BYTE_W;
  localparam int V_W    = SCL_W - FRAC_W;
  localparam int KEEP_N = 3;
  localparam int COMP_N = 4;

  localparam logic [ROOT_W-1:0] DIV_SEED      = 31'h1000_0000;
  localparam logic [COEF_W-1:0] INV_SQRT2_Q24 = 24'd11863283;
  localparam logic [W_W-1:0]    HALF_Q48      = 50'h8000_0000_0000;
  localparam logic [A_W-1:0]    A_MAX         = 25'h100_0000;
  localparam logic [BYTE_W-1:0] TAG_BASE      = 8'd252;
  localparam logic [BYTE_W-1:0] CODE_MID      = 8'd127;
  localparam logic [BYTE_W-1:0] BYTE_MAX      = 8'd255;

  typedef struct packed {
    logic                          vld;
    logic                          zero;
    logic [1:0]                    big;
    logic [KEEP_N-1:0]             neg;
    logic [KEEP_N-1:0][MAG_W-1:0]  kmag;
  } side_t;

endpackage

// ----- rtl/qs3_in_if.sv -----
interface qs3_in_if #(
  parameter int COMP_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] comp_zero;
  logic signed [COMP_WIDTH-1:0] comp_one;
  logic signed [COMP_WIDTH-1:0] comp_two;
  logic signed [COMP_WIDTH-1:0] comp_three;

  modport source (output valid, comp_zero, comp_one, comp_two, comp_three, input ready);
  modport sink (input valid, comp_zero, comp_one, comp_two, comp_three, output ready);
endinterface

// ----- rtl/qs3_out_if.sv -----
interface qs3_out_if import qs3_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_first;
  logic [BYTE_W-1:0] packed_second;
  logic [BYTE_W-1:0] packed_third;
  logic [BYTE_W-1:0] dropped_tag;

  modport source (output valid, packed_first, packed_second, packed_third, dropped_tag,
                  input ready);
  modport sink (input valid, packed_first, packed_second, packed_third, dropped_tag,
                output ready);
endinterface

// ----- rtl/qs3_root.sv -----
module qs3_root import qs3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [SUM_W-1:0]  sum_i,
  input  side_t             side_i,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic [SUM_W-1:0]  rem_r  [ROOT_W-1];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  // one root bit per stage, msb first
  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int B = ROOT_W - 1 - g;
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [TRY_W-1:0]  trial;
    logic              fit;
    logic [ROOT_W-1:0] root_nxt;

    if (g == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign trial    = (TRY_W'(root_in) << (B + 1)) | (TRY_W'(1) << (2 * B));
    assign fit      = TRY_W'(rem_in) >= trial;
    assign root_nxt = fit ? (root_in | (ROOT_W'(1) << B)) : root_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[g].vld <= 1'b0;
      end else if (adv) begin
        side_r[g] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[g] <= root_nxt;
      end
    end

    if (g < ROOT_W - 1) begin : g_rem
      logic [SUM_W-1:0] rem_nxt;
      assign rem_nxt = fit ? SUM_W'(TRY_W'(rem_in) - trial) : rem_in;
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[g] <= rem_nxt;
        end
      end
    end
  end

  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

// ----- rtl/qs3_recip.sv -----
module qs3_recip import qs3_pkg::*; #(
  parameter int RSQRT_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [ROOT_W-1:0]     len_i,
  input  side_t                 side_i,
  output logic [RSQRT_BITS+1:0] recip_o,
  output side_t                 side_o
);

  localparam int QB = RSQRT_BITS + 2;

  logic [ROOT_W-1:0] part_r [QB-1];
  logic [ROOT_W-1:0] len_r  [QB-1];
  logic [QB-1:0]     q_r    [QB];
  side_t             side_r [QB];

  // restoring long division of 2^(RSQRT_BITS+30) by the length, one quotient bit per stage
  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [ROOT_W-1:0] part_in;
    logic [ROOT_W-1:0] len_in;
    side_t             side_in;
    logic [ROOT_W:0]   dbl;
    logic              fit;
    logic [QB-1:0]     q_nxt;

    if (g == 0) begin : g_first
      assign part_in = DIV_SEED;
      assign len_in  = len_i;
      assign side_in = side_i;
      assign q_nxt   = QB'(fit);
    end else begin : g_next
      assign part_in = part_r[g-1];
      assign len_in  = len_r[g-1];
      assign side_in = side_r[g-1];
      assign q_nxt   = {q_r[g-1][QB-2:0], fit};
    end

    assign dbl = {part_in, 1'b0};
    assign fit = dbl >= {1'b0, len_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[g].vld <= 1'b0;
      end else if (adv) begin
        side_r[g] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[g] <= q_nxt;
      end
    end

    if (g < QB - 1) begin : g_part
      logic [ROOT_W-1:0] part_nxt;
      assign part_nxt = fit ? ROOT_W'(dbl - {1'b0, len_in}) : ROOT_W'(dbl);
      always_ff @(posedge clk) begin
        if (adv) begin
          part_r[g] <= part_nxt;
          len_r[g]  <= len_in;
        end
      end
    end
  end

  assign recip_o = q_r[QB-1];
  assign side_o  = side_r[QB-1];

endmodule

// ----- rtl/quaternion_smallest_three_pack_core.sv -----
// Smallest-three packer for rotation quaternions, one byte per kept component.
// in_chan carries the four signed components (COMP_WIDTH bits, any common
// scale), out_chan carries the three kept components as bytes in index order
// and a tag byte of 252 plus the index of the dropped (largest) component.
// Both channels use valid/ready; a request moves when both are high.
// One result per request, in request order. A request can be taken every
// cycle unless a stalled receiver holds off the input; the depth comes
// from the 31-stage square root and the RSQRT_BITS + 2 stage reciprocal
// divider, each resolving one bit per stage, plus the front end and the
// multipliers. All stages advance together; valid bits travel with the
// data. A stalled receiver holds the output register, and the pipeline
// keeps moving (and in_chan.ready stays high) as long as its last stage
// is empty, so bubbles are squeezed out before the input is held off.
// Synchronous reset clears every valid bit; the datapath holds no other
// state.
module quaternion_smallest_three_pack_core import qs3_pkg::*; #(
  parameter int COMP_WIDTH = 16,
  parameter int RSQRT_BITS = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  qs3_in_if.sink     in_chan,
  qs3_out_if.source  out_chan
);

  localparam int PW      = $clog2(COMP_WIDTH);
  localparam int SH_W    = PW + 1;
  localparam int EXT_W   = COMP_WIDTH + MAG_W;
  localparam int QB      = RSQRT_BITS + 2;
  localparam int RLO     = QB / 2;
  localparam int RHI     = QB - RLO;
  localparam int PROD_W  = MAG_W + QB;
  localparam int A_SHIFT = RSQRT_BITS + 6;

  logic adv;
  logic [COMP_N-1:0][COMP_WIDTH-1:0] comp;

  assign comp[0] = in_chan.comp_zero;
  assign comp[1] = in_chan.comp_one;
  assign comp[2] = in_chan.comp_two;
  assign comp[3] = in_chan.comp_three;

  // stage a: magnitudes
  logic                              a_vld_r;
  logic [COMP_N-1:0][COMP_WIDTH-1:0] a_mag_r, a_mag_nxt;
  logic [COMP_N-1:0]                 a_neg_r, a_neg_nxt;

  always_comb begin
    for (int k = 0; k < COMP_N; k++) begin
      a_neg_nxt[k] = comp[k][COMP_WIDTH-1];
      a_mag_nxt[k] = a_neg_nxt[k] ? (~comp[k] + 1'b1) : comp[k];
    end
  end

  // stage b: largest magnitude, lowest index wins ties
  logic                              b_vld_r;
  logic [COMP_N-1:0][COMP_WIDTH-1:0] b_mag_r;
  logic [COMP_N-1:0]                 b_neg_r;
  logic [1:0]                        b_big_r, b_big_nxt;
  logic [COMP_WIDTH-1:0]             b_mx_r, b_mx_nxt;

  always_comb begin
    b_big_nxt = 2'd0;
    b_mx_nxt  = a_mag_r[0];
    for (int k = 1; k < COMP_N; k++) begin
      if (a_mag_r[k] > b_mx_nxt) begin
        b_mx_nxt  = a_mag_r[k];
        b_big_nxt = 2'(k);
      end
    end
  end

  // stage c: msb position of the largest, signs folded with the flip
  logic                              c_vld_r;
  logic [COMP_N-1:0][COMP_WIDTH-1:0] c_mag_r;
  logic [COMP_N-1:0]                 c_neg_r, c_neg_nxt;
  logic [1:0]                        c_big_r;
  logic [PW-1:0]                     c_p_r, c_p_nxt;
  logic                              c_zero_r, c_zero_nxt;

  always_comb begin
    c_p_nxt = '0;
    for (int i = 0; i < COMP_WIDTH; i++) begin
      if (b_mx_r[i]) begin
        c_p_nxt = PW'(i);
      end
    end
    c_zero_nxt = (b_mx_r == '0);
    for (int k = 0; k < COMP_N; k++) begin
      c_neg_nxt[k] = b_neg_r[k] ^ b_neg_r[b_big_r];
    end
  end

  // stage d: common shift to put the largest at bit 29, pick the kept three
  logic [COMP_N-1:0][MAG_W-1:0] d_mag_r, d_mag_nxt;
  side_t                        d_side_r, d_side_nxt;

  always_comb begin
    logic [EXT_W-1:0] ext;
    logic [1:0]       src;
    for (int k = 0; k < COMP_N; k++) begin
      ext          = {c_mag_r[k], MAG_W'(0)} >> (SH_W'(c_p_r) + 1'b1);
      d_mag_nxt[k] = ext[MAG_W-1:0];
    end
    d_side_nxt.vld  = c_vld_r;
    d_side_nxt.zero = c_zero_r;
    d_side_nxt.big  = c_big_r;
    for (int j = 0; j < KEEP_N; j++) begin
      src                = (2'(j) < c_big_r) ? 2'(j) : 2'(j + 1);
      d_side_nxt.kmag[j] = d_mag_nxt[src];
      d_side_nxt.neg[j]  = c_neg_r[src];
    end
  end

  // stages e, f, g: squares and their sum
  logic [COMP_N-1:0][SQ_W-1:0] e_sq_r;
  side_t                       e_side_r;
  logic [1:0][SQ_W:0]          f_pair_r;
  side_t                       f_side_r;
  logic [SUM_W-1:0]            g_sum_r;
  side_t                       g_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      c_vld_r      <= 1'b0;
      d_side_r.vld <= 1'b0;
      e_side_r.vld <= 1'b0;
      f_side_r.vld <= 1'b0;
      g_side_r.vld <= 1'b0;
    end else if (adv) begin
      a_vld_r  <= in_chan.valid;
      b_vld_r  <= a_vld_r;
      c_vld_r  <= b_vld_r;
      d_side_r <= d_side_nxt;
      e_side_r <= d_side_r;
      f_side_r <= e_side_r;
      g_side_r <= f_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mag_r  <= a_mag_nxt;
      a_neg_r  <= a_neg_nxt;
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_big_r  <= b_big_nxt;
      b_mx_r   <= b_mx_nxt;
      c_mag_r  <= b_mag_r;
      c_neg_r  <= c_neg_nxt;
      c_big_r  <= b_big_r;
      c_p_r    <= c_p_nxt;
      c_zero_r <= c_zero_nxt;
      d_mag_r  <= d_mag_nxt;
      for (int k = 0; k < COMP_N; k++) begin
        e_sq_r[k] <= d_mag_r[k] * d_mag_r[k];
      end
      f_pair_r[0] <= (SQ_W + 1)'(e_sq_r[0]) + (SQ_W + 1)'(e_sq_r[1]);
      f_pair_r[1] <= (SQ_W + 1)'(e_sq_r[2]) + (SQ_W + 1)'(e_sq_r[3]);
      g_sum_r     <= SUM_W'(f_pair_r[0]) + SUM_W'(f_pair_r[1]);
    end
  end

  // length and reciprocal length
  logic [ROOT_W-1:0] root_len;
  side_t             root_side;
  logic [QB-1:0]     recip_val;
  side_t             recip_side;

  qs3_root u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .sum_i  (g_sum_r),
    .side_i (g_side_r),
    .root_o (root_len),
    .side_o (root_side)
  );

  qs3_recip #(
    .RSQRT_BITS (RSQRT_BITS)
  ) u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .len_i   (root_len),
    .side_i  (root_side),
    .recip_o (recip_val),
    .side_o  (recip_side)
  );

  // stages m1..m5: scale, map onto bytes
  logic [KEEP_N-1:0][MAG_W+RLO-1:0] m1_lo_r;
  logic [KEEP_N-1:0][MAG_W+RHI-1:0] m1_hi_r;
  side_t                            m1_side_r;
  logic [KEEP_N-1:0][A_W-1:0]       m2_a_r, m2_a_nxt;
  side_t                            m2_side_r;
  logic [KEEP_N-1:0][T_W-1:0]       m3_t_r;
  side_t                            m3_side_r;
  logic [KEEP_N-1:0][W_W-1:0]       m4_w_r, m4_w_nxt;
  side_t                            m4_side_r;
  logic                             m5_vld_r;
  logic [KEEP_N-1:0][BYTE_W-1:0]    m5_byte_r, m5_byte_nxt;
  logic [BYTE_W-1:0]                m5_tag_r, m5_tag_nxt;

  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int j = 0; j < KEEP_N; j++) begin
      prod        = PROD_W'(m1_lo_r[j]) + (PROD_W'(m1_hi_r[j]) << RLO);
      m2_a_nxt[j] = prod[A_SHIFT +: A_W];
    end
  end

  always_comb begin
    logic [W_W-1:0] tw;
    for (int j = 0; j < KEEP_N; j++) begin
      tw = W_W'(m3_t_r[j]);
      if (m3_side_r.neg[j]) begin
        m4_w_nxt[j] = (tw >= HALF_Q48) ? '0 : (HALF_Q48 - tw);
      end else begin
        m4_w_nxt[j] = HALF_Q48 + tw;
      end
    end
  end

  always_comb begin
    logic [SCL_W-1:0] scl;
    logic [V_W-1:0]   v;
    for (int j = 0; j < KEEP_N; j++) begin
      // 255 * w as (w << 8) - w
      scl = {m4_w_r[j], BYTE_W'(0)} - SCL_W'(m4_w_r[j]);
      v   = scl[SCL_W-1:FRAC_W];
      if (m4_side_r.zero) begin
        m5_byte_nxt[j] = CODE_MID;
      end else if (v > V_W'(BYTE_MAX)) begin
        m5_byte_nxt[j] = BYTE_MAX;
      end else begin
        m5_byte_nxt[j] = v[BYTE_W-1:0];
      end
    end
    m5_tag_nxt = m4_side_r.zero ? TAG_BASE : (TAG_BASE + BYTE_W'(m4_side_r.big));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_side_r.vld <= 1'b0;
      m2_side_r.vld <= 1'b0;
      m3_side_r.vld <= 1'b0;
      m4_side_r.vld <= 1'b0;
      m5_vld_r      <= 1'b0;
    end else if (adv) begin
      m1_side_r <= recip_side;
      m2_side_r <= m1_side_r;
      m3_side_r <= m2_side_r;
      m4_side_r <= m3_side_r;
      m5_vld_r  <= m4_side_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < KEEP_N; j++) begin
        m1_lo_r[j] <= (MAG_W + RLO)'(recip_side.kmag[j]) * (MAG_W + RLO)'(recip_val[RLO-1:0]);
        m1_hi_r[j] <= (MAG_W + RHI)'(recip_side.kmag[j]) * (MAG_W + RHI)'(recip_val[QB-1:RLO]);
        m3_t_r[j]  <= T_W'(m2_a_r[j]) * T_W'(INV_SQRT2_Q24);
      end
      m2_a_r    <= m2_a_nxt;
      m4_w_r    <= m4_w_nxt;
      m5_byte_r <= m5_byte_nxt;
      m5_tag_r  <= m5_tag_nxt;
    end
  end

  // output register
  logic                          out_vld_r, out_vld_nxt;
  logic [KEEP_N-1:0][BYTE_W-1:0] out_byte_r;
  logic [BYTE_W-1:0]             out_tag_r;
  logic                          take;

  assign adv         = !m5_vld_r || !out_vld_r || out_chan.ready;
  assign take        = m5_vld_r && adv;
  assign out_vld_nxt = take ? 1'b1 : (out_chan.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r <= m5_byte_r;
      out_tag_r  <= m5_tag_r;
    end
  end

  assign in_chan.ready          = adv;
  assign out_chan.valid         = out_vld_r;
  assign out_chan.packed_first  = out_byte_r[0];
  assign out_chan.packed_second = out_byte_r[1];
  assign out_chan.packed_third  = out_byte_r[2];
  assign out_chan.dropped_tag   = out_tag_r;

`ifndef SYNTHESIS
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (m5_vld_r && out_vld_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while the full pipeline is stalled");

  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    (root_side.vld && !root_side.zero) |-> (root_len[ROOT_W-1:ROOT_W-2] != 2'b00))
    else $error("length of a nonzero quaternion below 2^29");

  a_unit_scale: assert property (@(posedge clk) disable iff (!rst_n)
    m2_side_r.vld |-> (m2_a_r[0] <= A_MAX && m2_a_r[1] <= A_MAX && m2_a_r[2] <= A_MAX))
    else $error("normalized component above one");

  a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_chan.valid)
    else $error("result from the last stage did not reach the output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");
`endif

endmodule

// ----- dv/qs3_pack_checker.sv -----
module qs3_pack_checker import qs3_pkg::*; #(
  parameter int COMP_WIDTH = 16,
  parameter int RSQRT_BITS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  qs3_in_if           in_mon,
  qs3_out_if          out_mon,
  output int unsigned mismatches,
  output int unsigned pending_codes
);

  typedef logic [63:0] u64_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
    logic [BYTE_W-1:0] tag;
  } quat_code_t;

  quat_code_t expected_codes[$];
  quat_code_t want;

  function automatic u64_t floor_sqrt(u64_t radicand);
    u64_t root;
    u64_t trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (u64_t'(1) << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  // maps a Q0.24 magnitude from [-1/sqrt2, 1/sqrt2] onto 0..255
  function automatic logic [BYTE_W-1:0] to_byte(u64_t norm_mag, logic below_zero);
    u64_t scaled;
    u64_t shifted;
    u64_t level;
    scaled = norm_mag * u64_t'(INV_SQRT2_Q24);
    if (below_zero) begin
      shifted = (scaled >= u64_t'(HALF_Q48)) ? u64_t'(0) : u64_t'(HALF_Q48) - scaled;
    end else begin
      shifted = u64_t'(HALF_Q48) + scaled;
    end
    level = (u64_t'(255) * shifted) >> FRAC_W;
    return (level > u64_t'(BYTE_MAX)) ? BYTE_MAX : level[BYTE_W-1:0];
  endfunction

  function automatic quat_code_t pack_smallest_three(logic [3:0][COMP_WIDTH-1:0] comp);
    u64_t mag[4];
    logic sgn[4];
    logic [BYTE_W-1:0] kept[3];
    int lead;
    int lsh;
    int rsh;
    int slot;
    u64_t sumsq;
    u64_t len;
    u64_t recip;
    u64_t norm_mag;
    logic flip;
    quat_code_t res;
    for (int k = 0; k < 4; k++) begin
      sgn[k] = comp[k][COMP_WIDTH-1];
      mag[k] = sgn[k] ? (u64_t'(1) << COMP_WIDTH) - u64_t'(comp[k]) : u64_t'(comp[k]);
    end
    lead = 0;
    for (int k = 1; k < 4; k++) begin
      if (mag[k] > mag[lead]) lead = k;
    end
    if (mag[lead] == 0) begin
      res.first  = CODE_MID;
      res.second = CODE_MID;
      res.third  = CODE_MID;
      res.tag    = TAG_BASE;
      return res;
    end
    flip = sgn[lead];
    // bring the largest magnitude into [2^29, 2^30)
    lsh = 0;
    rsh = 0;
    while ((mag[lead] << lsh) < (u64_t'(1) << 29)) lsh++;
    while ((mag[lead] >> rsh) >= (u64_t'(1) << 30)) rsh++;
    sumsq = '0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = (mag[k] << lsh) >> rsh;
      sumsq += mag[k] * mag[k];
    end
    len = floor_sqrt(sumsq);
    if (len == 0) len = 1;
    recip = (u64_t'(1) << (RSQRT_BITS + 30)) / len;
    slot = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != lead) begin
        norm_mag = (mag[k] * recip) >> (RSQRT_BITS + 6);
        kept[slot] = to_byte(norm_mag, (mag[k] != 0) && (sgn[k] != flip));
        slot++;
      end
    end
    res.first  = kept[0];
    res.second = kept[1];
    res.third  = kept[2];
    res.tag    = TAG_BASE + BYTE_W'(lead);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] exp_val);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch("result with no request pending, tag", out_mon.dropped_tag, '0);
        end else begin
          want = expected_codes.pop_front();
          if (out_mon.packed_first !== want.first)
            report_mismatch("packed_first", out_mon.packed_first, want.first);
          if (out_mon.packed_second !== want.second)
            report_mismatch("packed_second", out_mon.packed_second, want.second);
          if (out_mon.packed_third !== want.third)
            report_mismatch("packed_third", out_mon.packed_third, want.third);
          if (out_mon.dropped_tag !== want.tag)
            report_mismatch("dropped_tag", out_mon.dropped_tag, want.tag);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_codes = {expected_codes,
                          pack_smallest_three({in_mon.comp_three, in_mon.comp_two,
                                               in_mon.comp_one, in_mon.comp_zero})};
      end
    end
    pending_codes <= expected_codes.size();
  end

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

  localparam int COMP_WIDTH   = 16;
  localparam int RSQRT_BITS   = 18;
  localparam int LATENCY      = RSQRT_BITS + 45;
  localparam int RANDOM_QUATS = 700;
  localparam int CALM_TAIL    = 100;
  localparam int CYCLE_LIMIT  = 200_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit idling = 1'b0;
  int unsigned mismatches;
  int unsigned pending_codes;
  logic [3:0][COMP_WIDTH-1:0] rand_quat;

  qs3_in_if #(.COMP_WIDTH(COMP_WIDTH)) in_chan ();
  qs3_out_if out_chan ();

  quaternion_smallest_three_pack_core #(
    .COMP_WIDTH(COMP_WIDTH),
    .RSQRT_BITS(RSQRT_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  qs3_pack_checker #(
    .COMP_WIDTH(COMP_WIDTH),
    .RSQRT_BITS(RSQRT_BITS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .mismatches    (mismatches),
    .pending_codes (pending_codes)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [COMP_WIDTH-1:0] with_sign(int unsigned m, int unsigned neg);
    return (neg != 0) ? COMP_WIDTH'(-m) : COMP_WIDTH'(m);
  endfunction

  function automatic logic [COMP_WIDTH-1:0] extreme_comp();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(COMP_WIDTH-1){1'b0}}};
      1: return {1'b0, {(COMP_WIDTH-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return COMP_WIDTH'(1);
      default: return COMP_WIDTH'($urandom);
    endcase
  endfunction

  task automatic make_random_quat(output logic [3:0][COMP_WIDTH-1:0] q);
    int unsigned lead_mag;
    int unsigned tie_a;
    int unsigned tie_b;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      for (int k = 0; k < 4; k++) q[k] = COMP_WIDTH'($urandom);
    end else if (pick <= 6) begin
      // rotation-like: one lead component, the rest bounded by its magnitude
      tie_a = $urandom_range(0, 3);
      lead_mag = $urandom_range(1 << (COMP_WIDTH - 3), (1 << (COMP_WIDTH - 1)) - 1);
      for (int k = 0; k < 4; k++) begin
        q[k] = with_sign((k == tie_a) ? lead_mag : $urandom_range(0, lead_mag),
                         $urandom_range(0, 1));
      end
    end else if (pick == 7) begin
      for (int k = 0; k < 4; k++) q[k] = with_sign($urandom_range(0, 3), $urandom_range(0, 1));
    end else if (pick == 8) begin
      for (int k = 0; k < 4; k++) q[k] = extreme_comp();
    end else begin
      // two components share the largest magnitude
      tie_a = $urandom_range(0, 3);
      tie_b = (tie_a + $urandom_range(1, 3)) % 4;
      lead_mag = $urandom_range(1, (1 << (COMP_WIDTH - 1)) - 1);
      for (int k = 0; k < 4; k++) begin
        q[k] = with_sign((k == tie_a || k == tie_b) ? lead_mag : $urandom_range(0, lead_mag),
                         $urandom_range(0, 1));
      end
    end
  endtask

  task automatic send_quat(input int q0, q1, q2, q3);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.comp_zero  <= COMP_WIDTH'(q0);
    in_chan.comp_one   <= COMP_WIDTH'(q1);
    in_chan.comp_two   <= COMP_WIDTH'(q2);
    in_chan.comp_three <= COMP_WIDTH'(q3);
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    out_chan.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    in_chan.valid      = 1'b0;
    in_chan.comp_zero  = '0;
    in_chan.comp_one   = '0;
    in_chan.comp_two   = '0;
    in_chan.comp_three = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idling = 1'b1;
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    send_quat(5, -5, 0, 0);
    send_quat(16384, 16384, 0, 0);
    send_quat(16384, -16384, 0, 0);
    send_quat(-32768, 0, 0, 0);
    send_quat(0, -32768, 32767, 0);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(1, 0, 0, 0);
    send_quat(0, 1, -1, 1);
    send_quat(0, 0, -1, 0);
    send_quat(-1, -1, -1, -1);
    send_quat(32767, -32768, 0, 0);
    send_quat(100, -200, 300, -32768);
    send_quat(21845, -21846, 21845, -21846);
    send_quat(-21846, 21845, -21846, 21845);
    send_quat(11585, 11585, 11585, 0);

    for (int n = 0; n < RANDOM_QUATS; n++) begin
      if (n % 50 == 0) begin
        idling = (n < RANDOM_QUATS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      end
      make_random_quat(rand_quat);
      send_quat(int'(rand_quat[0]), int'(rand_quat[1]), int'(rand_quat[2]),
                int'(rand_quat[3]));
    end
    in_chan.valid <= 1'b0;
    @(posedge clk);

    while (pending_codes != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_codes == 0) begin
      $display("PASS quaternion_smallest_three_pack_core");
    end else begin
      $display("FAIL quaternion_smallest_three_pack_core");
    end
    $finish;
  end

  initial begin
    #(4 * CYCLE_LIMIT);
    $display("FAIL quaternion_smallest_three_pack_core");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/qs3_pkg.sv
rtl/qs3_in_if.sv
rtl/qs3_out_if.sv
rtl/qs3_root.sv
rtl/qs3_recip.sv
rtl/quaternion_smallest_three_pack_core.sv
dv/qs3_pack_checker.sv
dv/tb_top.sv
